FILE: sv/pdlz_pkg.sv
// ----------------------------------------------------------------------------
// pdlz_pkg
// Shared codes and constants for the palmdoc lz77 record decompressor.
// ----------------------------------------------------------------------------
package pdlz_pkg;

  // decoder mode between input bytes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_IDLE    = 2'd0;
  localparam mode_t MODE_LITERAL = 2'd1;
  localparam mode_t MODE_PAIR    = 2'd2;

  // error code on a result
  typedef logic [1:0] err_t;
  localparam err_t ERR_NONE     = 2'd0;
  localparam err_t ERR_DISTANCE = 2'd1;
  localparam err_t ERR_TRUNC    = 2'd2;

  // source of the bytes emitted for one input byte
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PLAIN = 2'd0;
  localparam kind_t KIND_SPACE = 2'd1;
  localparam kind_t KIND_COPY  = 2'd2;

  // code byte ranges and fixed values
  localparam logic [7:0] LIT_COUNT_MIN  = 8'h01;
  localparam logic [7:0] LIT_COUNT_MAX  = 8'h08;
  localparam logic [7:0] PLAIN_MAX      = 8'h7F;
  localparam logic [7:0] SPACE_CODE_MIN = 8'hC0;
  localparam logic [7:0] SPACE_BYTE     = 8'h20;
  localparam logic [7:0] SPACE_TOGGLE   = 8'h80;
  localparam logic [3:0] COPY_LEN_BASE  = 4'd3;

  // copy distance width (11 bits of the 14-bit pair code)
  localparam int DIST_W = 11;

endpackage

FILE: sv/palmdoc_lz77_decompressor_unit.sv
// ----------------------------------------------------------------------------
// palmdoc_lz77_decompressor_unit
// Decodes a palmdoc lz77 record one compressed byte per transaction into
// a stream of decompressed bytes, with distance and truncation errors.
// ----------------------------------------------------------------------------
// A byte is accepted, decoded in the next cycle, and its first result is
// registered in S_EMIT (copies first pass S_READ for the history read).
// A new byte is taken only in S_IDLE, after the last one's output; emits wait
// on out_stall, and the history memory is read, then written, per copied byte.
// Reset clears the sequencer, pointers and decoder mode; history is not cleared.
// ----------------------------------------------------------------------------
module palmdoc_lz77_decompressor_unit #(
  parameter int HISTORY_DEPTH = 2048
) (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       first_of_record,
  input  logic       last_of_record,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_item,
  output logic [1:0] error,
  output logic       record_end
);

  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_ERR    = 3'd4;

  logic [2:0]               state, state_next;
  logic [7:0]               hold_byte, hold_byte_next;
  logic                     hold_last, hold_last_next;
  logic [PTR_W-1:0]         wp, wp_next;
  logic [CNT_W-1:0]         produced, produced_next;
  pdlz_pkg::mode_t          mode, mode_next;
  logic [3:0]               lit_left, lit_left_next;
  logic [5:0]               pair_hi, pair_hi_next;
  pdlz_pkg::kind_t          kind, kind_next;
  logic [3:0]               rem, rem_next;
  logic [pdlz_pkg::DIST_W-1:0] copy_dist, copy_dist_next;
  logic                     trunc, trunc_next;
  pdlz_pkg::err_t           err_code, err_code_next;
  logic                     out_valid_next;
  logic [7:0]               out_byte_next;
  logic                     last_of_item_next;
  logic [1:0]               error_next;
  logic                     record_end_next;

  // history memory
  logic [7:0]       history [HISTORY_DEPTH];
  logic [7:0]       mem_q;
  logic             mem_we;
  logic [7:0]       emit_val;
  logic [PTR_W-1:0] rd_addr;
  logic [PTR_W:0]   rd_wrap;
  logic             out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // copy source address, modulo the history depth
  assign rd_wrap = {1'b0, wp} + (PTR_W + 1)'(HISTORY_DEPTH) - (PTR_W + 1)'(copy_dist);
  assign rd_addr = ({1'b0, wp} >= (PTR_W + 1)'(copy_dist)) ? (wp - PTR_W'(copy_dist))
                                                             : rd_wrap[PTR_W-1:0];

  // byte selected for the current emit step
  always_comb begin
    case (kind)
      pdlz_pkg::KIND_COPY:  emit_val = mem_q;
      pdlz_pkg::KIND_SPACE: emit_val = (rem == 4'd2) ? pdlz_pkg::SPACE_BYTE
                                       : (hold_byte ^ pdlz_pkg::SPACE_TOGGLE);
      default:              emit_val = hold_byte;
    endcase
  end

  // sequencer and decoder
  always_comb begin
    pdlz_pkg::mode_t          mode_after;
    logic [pdlz_pkg::DIST_W-1:0] pair_dist;
    logic                     emits;
    logic                     dist_bad;

    mode_after = mode;
    pair_dist  = {pair_hi, hold_byte[7:3]};
    emits      = 1'b0;
    dist_bad   = 1'b0;

    state_next        = state;
    hold_byte_next    = hold_byte;
    hold_last_next    = hold_last;
    wp_next           = wp;
    produced_next     = produced;
    mode_next         = mode;
    lit_left_next     = lit_left;
    pair_hi_next      = pair_hi;
    kind_next         = kind;
    rem_next          = rem;
    copy_dist_next    = copy_dist;
    trunc_next        = trunc;
    err_code_next     = err_code;
    out_valid_next    = out_valid && out_stall;
    out_byte_next     = out_byte;
    last_of_item_next = last_of_item;
    error_next        = error;
    record_end_next   = record_end;
    mem_we            = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          hold_byte_next = in_byte;
          hold_last_next = last_of_record;
          if (first_of_record) begin
            wp_next       = '0;
            produced_next = '0;
            mode_next     = pdlz_pkg::MODE_IDLE;
            lit_left_next = '0;
            pair_hi_next  = '0;
          end
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        // classify the byte against the current mode
        unique case (mode)
          pdlz_pkg::MODE_LITERAL: begin
            emits     = 1'b1;
            kind_next = pdlz_pkg::KIND_PLAIN;
            rem_next  = 4'd1;
            lit_left_next = (lit_left == 4'd0) ? 4'd0 : lit_left - 4'd1;
            mode_after = (lit_left <= 4'd1) ? pdlz_pkg::MODE_IDLE
                                            : pdlz_pkg::MODE_LITERAL;
          end
          pdlz_pkg::MODE_PAIR: begin
            mode_after   = pdlz_pkg::MODE_IDLE;
            pair_hi_next = '0;
            dist_bad = (pair_dist == '0) || (CNT_W'(pair_dist) > produced);
            if (!dist_bad) begin
              emits          = 1'b1;
              kind_next      = pdlz_pkg::KIND_COPY;
              rem_next       = {1'b0, hold_byte[2:0]} + pdlz_pkg::COPY_LEN_BASE;
              copy_dist_next = pair_dist;
            end
          end
          default: begin
            if (hold_byte >= pdlz_pkg::LIT_COUNT_MIN &&
                hold_byte <= pdlz_pkg::LIT_COUNT_MAX) begin
              lit_left_next = hold_byte[3:0];
              mode_after    = pdlz_pkg::MODE_LITERAL;
            end else if (hold_byte <= pdlz_pkg::PLAIN_MAX) begin
              emits     = 1'b1;
              kind_next = pdlz_pkg::KIND_PLAIN;
              rem_next  = 4'd1;
            end else if (hold_byte >= pdlz_pkg::SPACE_CODE_MIN) begin
              emits     = 1'b1;
              kind_next = pdlz_pkg::KIND_SPACE;
              rem_next  = 4'd2;
            end else begin
              pair_hi_next = hold_byte[5:0];
              mode_after   = pdlz_pkg::MODE_PAIR;
            end
          end
        endcase

        mode_next  = mode_after;
        trunc_next = hold_last && (mode_after != pdlz_pkg::MODE_IDLE);
        if (hold_last) begin
          mode_next     = pdlz_pkg::MODE_IDLE;
          lit_left_next = '0;
          pair_hi_next  = '0;
        end

        if (dist_bad) begin
          err_code_next = pdlz_pkg::ERR_DISTANCE;
          state_next    = S_ERR;
        end else if (emits) begin
          state_next = (kind_next == pdlz_pkg::KIND_COPY) ? S_READ : S_EMIT;
        end else if (hold_last && (mode_after != pdlz_pkg::MODE_IDLE)) begin
          err_code_next = pdlz_pkg::ERR_TRUNC;
          state_next    = S_ERR;
        end else begin
          state_next = S_IDLE;
        end
      end

      S_READ: begin
        state_next = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_next    = 1'b1;
          out_byte_next     = emit_val;
          error_next        = pdlz_pkg::ERR_NONE;
          last_of_item_next = (rem == 4'd1) && !trunc;
          record_end_next   = (rem == 4'd1) && !trunc && hold_last;
          mem_we            = 1'b1;
          wp_next = (wp == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp + 1'b1;
          if (produced != CNT_W'(HISTORY_DEPTH)) begin
            produced_next = produced + 1'b1;
          end
          rem_next = rem - 4'd1;
          if (rem == 4'd1) begin
            err_code_next = pdlz_pkg::ERR_TRUNC;
            state_next    = trunc ? S_ERR : S_IDLE;
          end else begin
            state_next = (kind == pdlz_pkg::KIND_COPY) ? S_READ : S_EMIT;
          end
        end
      end

      S_ERR: begin
        if (out_free) begin
          out_valid_next    = 1'b1;
          out_byte_next     = '0;
          error_next        = err_code;
          last_of_item_next = 1'b1;
          record_end_next   = hold_last;
          state_next        = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      wp        <= '0;
      produced  <= '0;
      mode      <= pdlz_pkg::MODE_IDLE;
      lit_left  <= '0;
      pair_hi   <= '0;
      trunc     <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      wp        <= wp_next;
      produced  <= produced_next;
      mode      <= mode_next;
      lit_left  <= lit_left_next;
      pair_hi   <= pair_hi_next;
      trunc     <= trunc_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hold_byte    <= hold_byte_next;
    hold_last    <= hold_last_next;
    kind         <= kind_next;
    rem          <= rem_next;
    copy_dist    <= copy_dist_next;
    err_code     <= err_code_next;
    out_byte     <= out_byte_next;
    last_of_item <= last_of_item_next;
    error        <= error_next;
    record_end   <= record_end_next;
  end

  // history memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      history[wp] <= emit_val;
    end
    if (state == S_READ) begin
      mem_q <= history[rd_addr];
    end
  end

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error != pdlz_pkg::ERR_NONE) |-> out_byte == 8'h00)
    else $error("error result carries nonzero byte");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_end |-> last_of_item)
    else $error("record end without last of item");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    produced <= CNT_W'(HISTORY_DEPTH))
    else $error("produced count past history depth");

  a_emit_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) || (state == S_READ) |-> rem != 4'd0)
    else $error("emit step with nothing left");

endmodule
